FILE: sv/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

   localparam int unsigned CHAR_W       = 8;
   localparam int unsigned POS_W        = 10;
   localparam int unsigned ADDR_W       = 16;
   localparam int unsigned EXT_W        = 17;
   localparam int unsigned CODE_W       = 3;
   localparam int unsigned KIND_W       = 2;
   localparam int unsigned REQ_DATA_W   = 8;
   localparam int unsigned RSP_DATA_W   = 48;
   localparam int unsigned RSP_USED_W   = EXT_W + CHAR_W + CODE_W + EXT_W;
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CHAR_W-1:0] COLON_CHAR   = 8'd58;
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
   localparam logic [POS_W-1:0]  POS_MAX      = 10'd1023;

   localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RECORD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

   localparam logic [CODE_W-1:0] ERR_NO_COLON  = 3'd0;
   localparam logic [CODE_W-1:0] ERR_TOO_SHORT = 3'd1;
   localparam logic [CODE_W-1:0] ERR_LENGTH    = 3'd2;
   localparam logic [CODE_W-1:0] ERR_BAD_HEX   = 3'd3;
   localparam logic [CODE_W-1:0] ERR_CHECKSUM  = 3'd4;

   // One classified character as it travels from the front to the back.
   typedef struct packed {
      logic       is_newline;
      logic       is_colon;
      logic       hex_ok;
      logic [3:0] nibble;
   } char_class_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic char_class_type classify(input logic [CHAR_W-1:0] c);
      char_class_type r;
      r.is_newline = (c == NEWLINE_CHAR);
      r.is_colon   = (c == COLON_CHAR);
      r.hex_ok     = 1'b1;
      r.nibble     = 4'd0;
      if (c >= 8'd48 && c <= 8'd57) begin
         r.nibble = 4'(c - 8'd48);
      end else if (c >= 8'd65 && c <= 8'd70) begin
         r.nibble = 4'(c - 8'd55);
      end else if (c >= 8'd97 && c <= 8'd102) begin
         r.nibble = 4'(c - 8'd87);
      end else begin
         r.hex_ok = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: sv/ihex_front.sv
`default_nettype none

module ihex_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [ihex_pkg::CHAR_W-1:0]   char_code,
   input  wire ihex_pkg::queue_status_type    q_status,
   output logic                               push,
   output ihex_pkg::char_class_type           push_item
);
   import ihex_pkg::*;

   // Incoming beats are classified once here, so the back only sees decoded flags.
   logic seen_reset_ff;
   logic seen_reset_in;

   assign seen_reset_in = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_reset_ff <= 1'b0;
      end else begin
         seen_reset_ff <= seen_reset_in;
      end
   end

   assign req_tready = seen_reset_ff && !q_status.full;
   assign push       = req_tvalid && req_tready;
   assign push_item  = classify(char_code);

endmodule

`default_nettype wire

FILE: sv/ihex_queue.sv
`default_nettype none

module ihex_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire ihex_pkg::char_class_type    push_item,
   input  wire logic                        pop,
   output ihex_pkg::char_class_type         pop_item,
   output ihex_pkg::queue_status_type       q_status
);
   import ihex_pkg::*;

   char_class_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   do_push, do_pop;

   assign q_status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_item       = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: sv/ihex_back.sv
`default_nettype none

module ihex_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ihex_pkg::queue_status_type    q_status,
   input  wire ihex_pkg::char_class_type      item,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [ihex_pkg::KIND_W-1:0]        kind,
   output logic [ihex_pkg::EXT_W-1:0]         write_address,
   output logic [ihex_pkg::CHAR_W-1:0]        write_data,
   output logic [ihex_pkg::CODE_W-1:0]        error_code,
   output logic [ihex_pkg::EXT_W-1:0]         image_length
);
   import ihex_pkg::*;

   logic [POS_W-1:0]  char_position_ff, char_position_in;
   logic [CHAR_W-1:0] byte_count_ff, byte_count_in;
   logic [CHAR_W-1:0] record_type_ff, record_type_in;
   logic [ADDR_W-1:0] record_address_ff, record_address_in;
   logic [3:0]        high_nibble_ff, high_nibble_in;
   logic [CHAR_W-1:0] running_sum_ff, running_sum_in;
   logic              addr_bad_ff, addr_bad_in;
   logic [EXT_W-1:0]  extent_ff, extent_in;
   logic              halted_ff, halted_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [EXT_W-1:0]  waddr_ff, waddr_in;
   logic [CHAR_W-1:0] wdata_ff, wdata_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [EXT_W-1:0]  length_ff, length_in;

   logic              emit;
   logic              fail;
   logic [KIND_W-1:0] emit_kind;
   logic [EXT_W-1:0]  emit_addr;
   logic [CHAR_W-1:0] emit_data;
   logic [CODE_W-1:0] emit_code;

   logic [POS_W-1:0]  h;
   logic [POS_W-1:0]  line_len;
   logic [POS_W-1:0]  end_data;
   logic [POS_W-1:0]  data_off;
   logic [CHAR_W-1:0] cur_byte;
   logic [EXT_W-1:0]  data_addr;
   logic [EXT_W-1:0]  data_addr_p1;

   // The output register can be refilled in the same cycle its beat is taken.
   assign pop = !q_status.empty && (!rsp_valid_ff || rsp_tready);

   assign h            = char_position_ff - 1'b1;
   assign line_len     = char_position_ff - 1'b1;
   assign end_data     = 10'd8 + {1'b0, byte_count_ff, 1'b0};
   assign data_off     = h - 10'd8;
   assign cur_byte     = {high_nibble_ff, item.nibble};
   assign data_addr    = {1'b0, record_address_ff} + EXT_W'(data_off[POS_W-1:1]);
   assign data_addr_p1 = data_addr + 1'b1;

   always_comb begin
      char_position_in  = char_position_ff;
      byte_count_in     = byte_count_ff;
      record_type_in    = record_type_ff;
      record_address_in = record_address_ff;
      high_nibble_in    = high_nibble_ff;
      running_sum_in    = running_sum_ff;
      addr_bad_in       = addr_bad_ff;
      extent_in         = extent_ff;
      emit              = 1'b0;
      fail              = 1'b0;
      emit_kind         = KIND_RECORD;
      emit_addr         = '0;
      emit_data         = '0;
      emit_code         = ERR_NO_COLON;

      if (pop && !halted_ff) begin
         if (item.is_newline) begin
            if (char_position_ff != '0) begin
               char_position_in  = '0;
               byte_count_in     = '0;
               record_type_in    = '0;
               record_address_in = '0;
               high_nibble_in    = '0;
               running_sum_in    = '0;
               addr_bad_in       = 1'b0;
               if (line_len < 10'd10) begin
                  fail      = 1'b1;
                  emit_code = ERR_TOO_SHORT;
               end else if (line_len < 10'd10 + {1'b0, byte_count_ff, 1'b0}) begin
                  fail      = 1'b1;
                  emit_code = ERR_LENGTH;
               end else begin
                  emit      = 1'b1;
                  emit_kind = KIND_RECORD;
               end
            end
         end else if (char_position_ff == '0) begin
            if (item.is_colon) begin
               char_position_in = 10'd1;
            end else begin
               fail      = 1'b1;
               emit_code = ERR_NO_COLON;
            end
         end else begin
            if (char_position_ff != POS_MAX) begin
               char_position_in = char_position_ff + 1'b1;
            end
            if (h < 10'd8) begin
               // Header digits: count, address, type.
               if ((h < 10'd2 || h >= 10'd6) && !item.hex_ok) begin
                  fail      = 1'b1;
                  emit_code = ERR_BAD_HEX;
               end else begin
                  if (h >= 10'd2 && h < 10'd6) begin
                     if (!item.hex_ok) begin
                        addr_bad_in = 1'b1;
                     end
                     record_address_in = {record_address_ff[ADDR_W-5:0], item.nibble};
                  end
                  if (!h[0]) begin
                     high_nibble_in = item.nibble;
                  end else begin
                     running_sum_in = running_sum_ff + cur_byte;
                     if (h == 10'd1) begin
                        byte_count_in = cur_byte;
                     end
                     if (h == 10'd7) begin
                        record_type_in = cur_byte;
                        if (cur_byte == '0 && addr_bad_ff) begin
                           fail      = 1'b1;
                           emit_code = ERR_BAD_HEX;
                        end
                     end
                  end
               end
            end else if (record_type_ff == '0 && h < end_data + 10'd2) begin
               if (!item.hex_ok) begin
                  fail      = 1'b1;
                  emit_code = ERR_BAD_HEX;
               end else if (!h[0]) begin
                  high_nibble_in = item.nibble;
               end else if (h < end_data) begin
                  running_sum_in = running_sum_ff + cur_byte;
                  if (data_addr_p1 > extent_ff) begin
                     extent_in = data_addr_p1;
                  end
                  emit      = 1'b1;
                  emit_kind = KIND_WRITE;
                  emit_addr = data_addr;
                  emit_data = cur_byte;
               end else if (8'(8'd0 - running_sum_ff) != cur_byte) begin
                  fail      = 1'b1;
                  emit_code = ERR_CHECKSUM;
               end
            end
         end
      end

      halted_in = halted_ff || fail;
      if (fail) begin
         emit      = 1'b1;
         emit_kind = KIND_ERROR;
      end else begin
         emit_code = ERR_NO_COLON;
      end

      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      waddr_in     = waddr_ff;
      wdata_in     = wdata_ff;
      code_in      = code_ff;
      length_in    = length_ff;
      if (pop) begin
         rsp_valid_in = emit;
         kind_in      = emit_kind;
         waddr_in     = emit_addr;
         wdata_in     = emit_data;
         code_in      = emit_code;
         length_in    = extent_in;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_position_ff  <= '0;
         byte_count_ff     <= '0;
         record_type_ff    <= '0;
         record_address_ff <= '0;
         high_nibble_ff    <= '0;
         running_sum_ff    <= '0;
         addr_bad_ff       <= 1'b0;
         extent_ff         <= '0;
         halted_ff         <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         char_position_ff  <= char_position_in;
         byte_count_ff     <= byte_count_in;
         record_type_ff    <= record_type_in;
         record_address_ff <= record_address_in;
         high_nibble_ff    <= high_nibble_in;
         running_sum_ff    <= running_sum_in;
         addr_bad_ff       <= addr_bad_in;
         extent_ff         <= extent_in;
         halted_ff         <= halted_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      waddr_ff  <= waddr_in;
      wdata_ff  <= wdata_in;
      code_ff   <= code_in;
      length_ff <= length_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign kind          = kind_ff;
   assign write_address = waddr_ff;
   assign write_data    = wdata_ff;
   assign error_code    = code_ff;
   assign image_length  = length_ff;

endmodule

`default_nettype wire

FILE: sv/intel_hex_record_loader_top.sv
`default_nettype none

// Channel  Dir  Ports                    Contents
// req      in   req_tvalid/tready/tdata  tdata[7:0] char_code
// rsp      out  rsp_tvalid/tready/tdata  tdata: write_address, write_data, error_code,
//                 /tuser                  image_length; tuser: kind
//
// One character per cycle is sustained while results are taken; the back consumes
// one beat a cycle from a four-entry queue whenever its output register is empty or
// being drained. An accepted character is queued; the back registers its result on pop.
// Synchronous reset clears the line state, the image length and the error halt;
// req_tready rises in the cycle after reset drops.
// A stalled result stops the back; the front keeps taking beats until the queue fills.
module intel_hex_record_loader_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [ihex_pkg::REQ_DATA_W-1:0]     req_tdata,  // [7:0] char_code
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [16:0] write_address, [24:17] write_data, [27:25] error_code,
   // [44:28] image_length, [47:45] zero
   output logic [ihex_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic [ihex_pkg::KIND_W-1:0]              rsp_tuser   // [1:0] kind
);
   import ihex_pkg::*;

   queue_status_type q_status;
   char_class_type   push_item;
   char_class_type   pop_item;
   logic             push;
   logic             pop;
   logic [EXT_W-1:0]  write_address;
   logic [CHAR_W-1:0] write_data;
   logic [CODE_W-1:0] error_code;
   logic [EXT_W-1:0]  image_length;

   ihex_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .char_code  (req_tdata[CHAR_W-1:0]),
      .q_status   (q_status),
      .push       (push),
      .push_item  (push_item)
   );

   ihex_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   ihex_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .item          (pop_item),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .kind          (rsp_tuser),
      .write_address (write_address),
      .write_data    (write_data),
      .error_code    (error_code),
      .image_length  (image_length)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RSP_USED_W){1'b0}},
                       image_length, error_code, write_data, write_address};

endmodule

`default_nettype wire

FILE: bench/intel_hex_record_loader_top_test.sv
module intel_hex_record_loader_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ihex_pkg::*;

   localparam logic [CHAR_W-1:0] CR_CHAR = 8'd13;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_CHARS = 1800;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [EXT_W-1:0]  wr_addr;
      logic [CHAR_W-1:0] wr_data;
      logic [CODE_W-1:0] code;
      logic [EXT_W-1:0]  image_len;
   } loader_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;

   intel_hex_record_loader_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Text waiting to be sent, and the line under construction.
   logic [CHAR_W-1:0] send_q[$];
   logic [CHAR_W-1:0] line_buf[$];
   loader_result_t    expected_results[$];

   int  total_chars = 0;
   int  sent_chars = 0;
   int  cycle_count = 0;
   int  mismatch_count = 0;
   int  drain_point = 0;
   bit  draining = 1'b0;
   bit  drained = 1'b0;
   bit  char_taken = 1'b0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;

   loader_result_t got, want;

   // Line decoder state, mirrored from the block.
   logic [POS_W-1:0]  line_pos;
   logic [7:0]        count_byte;
   logic [7:0]        type_byte;
   logic [ADDR_W-1:0] rec_addr;
   logic [3:0]        hi_nib;
   logic [7:0]        line_sum;
   logic              addr_digit_bad;
   logic [EXT_W-1:0]  image_extent;
   logic              halted;

   function automatic bit hex_digit(input logic [CHAR_W-1:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= 8'd48 && c <= 8'd57) begin
         v = 4'(c - 8'd48);
         return 1'b1;
      end
      if (c >= 8'd65 && c <= 8'd70) begin
         v = 4'(c - 8'd55);
         return 1'b1;
      end
      if (c >= 8'd97 && c <= 8'd102) begin
         v = 4'(c - 8'd87);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic clear_line();
      line_pos = '0;
      count_byte = '0;
      type_byte = '0;
      rec_addr = '0;
      hi_nib = '0;
      line_sum = '0;
      addr_digit_bad = 1'b0;
   endtask

   task automatic expect_result(input logic [KIND_W-1:0] kind, input logic [EXT_W-1:0] wa,
                                input logic [CHAR_W-1:0] wd, input logic [CODE_W-1:0] code);
      loader_result_t r;
      r.kind = kind;
      r.wr_addr = wa;
      r.wr_data = wd;
      r.code = code;
      r.image_len = image_extent;
      expected_results.push_back(r);
   endtask

   task automatic raise_fault(input logic [CODE_W-1:0] code);
      halted = 1'b1;
      expect_result(KIND_ERROR, '0, '0, code);
   endtask

   // Advances the decoder by one character and queues any result it causes.
   task automatic decode_char(input logic [CHAR_W-1:0] c);
      int unsigned k, h, len, cnt, end_data, wa;
      logic [3:0] nib;
      logic [7:0] val;
      bit ok;
      if (halted) return;
      k = line_pos;
      if (c == NEWLINE_CHAR) begin
         if (k == 0) return;
         len = k - 1;
         cnt = count_byte;
         clear_line();
         if (len < 10) raise_fault(ERR_TOO_SHORT);
         else if (len < 10 + 2 * cnt) raise_fault(ERR_LENGTH);
         else expect_result(KIND_RECORD, '0, '0, '0);
         return;
      end
      if (k == 0) begin
         if (c != COLON_CHAR) raise_fault(ERR_NO_COLON);
         else line_pos = 1;
         return;
      end
      h = k - 1;
      if (k < POS_MAX) line_pos = POS_W'(k + 1);
      ok = hex_digit(c, nib);
      if (h < 8) begin
         // A bad address digit only matters once the type turns out to be data.
         if (h >= 2 && h < 6) begin
            if (!ok) addr_digit_bad = 1'b1;
            rec_addr = {rec_addr[11:0], nib};
         end else if (!ok) begin
            raise_fault(ERR_BAD_HEX);
            return;
         end
         if (h % 2 == 0) begin
            hi_nib = nib;
            return;
         end
         val = {hi_nib, nib};
         line_sum = line_sum + val;
         if (h == 1) count_byte = val;
         if (h == 7) begin
            type_byte = val;
            if (val == 8'd0 && addr_digit_bad) raise_fault(ERR_BAD_HEX);
         end
         return;
      end
      if (type_byte != 8'd0) return;
      end_data = 8 + 2 * count_byte;
      if (h >= end_data + 2) return;
      if (!ok) begin
         raise_fault(ERR_BAD_HEX);
         return;
      end
      if (h % 2 == 0) begin
         hi_nib = nib;
         return;
      end
      val = {hi_nib, nib};
      if (h < end_data) begin
         wa = rec_addr + (h - 8) / 2;
         line_sum = line_sum + val;
         if (wa + 1 > image_extent) image_extent = EXT_W'(wa + 1);
         expect_result(KIND_WRITE, EXT_W'(wa), val, '0);
      end else if (8'(8'd0 - line_sum) != val) begin
         raise_fault(ERR_CHECKSUM);
      end
   endtask

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'd48 + v;
      return ($urandom_range(0, 1) ? 8'd55 : 8'd87) + v;
   endfunction

   function automatic logic [CHAR_W-1:0] junk_char();
      logic [CHAR_W-1:0] c;
      do c = 8'($urandom); while (c == NEWLINE_CHAR);
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] non_hex_char();
      logic [CHAR_W-1:0] c;
      logic [3:0] nib;
      do c = 8'($urandom); while (hex_digit(c, nib) || c == NEWLINE_CHAR);
      return c;
   endfunction

   task automatic put_byte(input logic [7:0] b);
      line_buf.push_back(hex_char(b[7:4]));
      line_buf.push_back(hex_char(b[3:0]));
   endtask

   // Builds a well-formed record with random data and a correct checksum, no newline.
   task automatic build_record(input logic [7:0] cnt, input logic [15:0] addr,
                               input logic [7:0] rtype);
      logic [7:0] sum, b;
      line_buf.delete();
      line_buf.push_back(COLON_CHAR);
      sum = cnt + addr[15:8] + addr[7:0] + rtype;
      put_byte(cnt);
      put_byte(addr[15:8]);
      put_byte(addr[7:0]);
      put_byte(rtype);
      for (int i = 0; i < cnt; i++) begin
         b = 8'($urandom);
         put_byte(b);
         sum = sum + b;
      end
      put_byte(8'(8'd0 - sum));
   endtask

   task automatic commit_line();
      foreach (line_buf[i]) send_q.push_back(line_buf[i]);
      send_q.push_back(NEWLINE_CHAR);
   endtask

   // Driver: presents characters and rsp_tready at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         case (total_chars > 0 ? (sent_chars * 3) / total_chars : 2)
            0: begin
               send_idle_pct = 23;
               recv_stall_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               recv_stall_pct = 23;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         if (!drained && !draining && sent_chars >= drain_point && expected_results.size() != 0)
            draining = 1'b1;
         if (draining && expected_results.size() == 0) begin
            draining = 1'b0;
            drained = 1'b1;
         end
         if (!req_tvalid || char_taken) begin
            if (send_q.size() != 0 && !draining && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= send_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         char_taken = 1'b0;
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Monitor: samples both channels at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_line();
         image_extent = '0;
         halted = 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            if (req_tvalid && req_tready) begin
               decode_char(req_tdata);
               sent_chars++;
               char_taken = 1'b1;
            end
            if (rsp_tvalid && rsp_tready) begin
               got.kind = rsp_tuser;
               got.wr_addr = rsp_tdata[16:0];
               got.wr_data = rsp_tdata[24:17];
               got.code = rsp_tdata[27:25];
               got.image_len = rsp_tdata[44:28];
               if (expected_results.size() == 0) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("unexpected beat: kind %0d addr %h data %h code %0d len %h",
                              got.kind, got.wr_addr, got.wr_data, got.code, got.image_len);
               end else begin
                  want = expected_results.pop_front();
                  if (got.kind != want.kind || got.wr_addr != want.wr_addr ||
                      got.wr_data != want.wr_data || got.code != want.code ||
                      got.image_len != want.image_len || rsp_tdata[47:45] != 3'd0) begin
                     mismatch_count++;
                     if (mismatch_count <= MAX_REPORTS) begin
                        $write("mismatch: expected kind %0d addr %h data %h code %0d len %h,",
                               want.kind, want.wr_addr, want.wr_data, want.code,
                               want.image_len);
                        $display(" got kind %0d addr %h data %h code %0d len %h pad %h",
                                 got.kind, got.wr_addr, got.wr_data, got.code,
                                 got.image_len, rsp_tdata[47:45]);
                     end
                  end
               end
            end
         end
      end
   end

   initial begin
      int line_no, big_at, pick, extra, pos, last;
      logic [7:0] cnt;
      logic [15:0] addr;
      logic [3:0] nib;

      // Directed lines: an empty line, a one-byte write at the top address, and a
      // non-data record whose bad address digit must be ignored.
      send_q.push_back(NEWLINE_CHAR);
      build_record(8'd1, 16'hFFFF, 8'h00);
      commit_line();
      build_record(8'd0, 16'h0000, 8'h01);
      line_buf[3] = non_hex_char();
      commit_line();

      line_no = 0;
      big_at = $urandom_range(5, 40);
      while (send_q.size() < RANDOM_CHARS) begin
         line_no++;
         pick = $urandom_range(0, 99);
         if (line_no == big_at) begin
            build_record(8'hFF, 16'($urandom), 8'h00);
            commit_line();
         end else if (pick < 10) begin
            send_q.push_back(NEWLINE_CHAR);
         end else if (pick < 75) begin
            cnt = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 40)
                                                 : $urandom_range(0, 16));
            addr = ($urandom_range(0, 4) == 0) ? 16'(16'hFFF0 + $urandom_range(0, 15))
                                               : 16'($urandom);
            build_record(cnt, addr, 8'h00);
            // Anything after the checksum of a data record is ignored.
            if ($urandom_range(0, 1))
               repeat ($urandom_range(1, 3))
                  line_buf.push_back(($urandom_range(0, 2) == 0) ? CR_CHAR : junk_char());
            commit_line();
         end else begin
            build_record(8'($urandom_range(0, 16)), 16'($urandom),
                         8'($urandom_range(1, 255)));
            for (int i = 9; i < line_buf.size(); i++)
               if ($urandom_range(0, 1)) line_buf[i] = junk_char();
            if ($urandom_range(0, 2) == 0) line_buf[1 + $urandom_range(2, 5)] = non_hex_char();
            if ($urandom_range(0, 1))
               repeat ($urandom_range(1, 4)) line_buf.push_back(junk_char());
            commit_line();
         end
      end

      // The first fault halts the block for good, so at most one ends the text.
      pick = $urandom_range(0, 6);
      case (pick)
         1: begin
            if ($urandom_range(0, 1)) begin
               send_q.push_back(CR_CHAR);
            end else begin
               do cnt = 8'($urandom); while (cnt == COLON_CHAR || cnt == NEWLINE_CHAR);
               send_q.push_back(cnt);
            end
            send_q.push_back(NEWLINE_CHAR);
         end
         2: begin
            line_buf.delete();
            line_buf.push_back(COLON_CHAR);
            repeat ($urandom_range(0, 9)) line_buf.push_back(hex_char(4'($urandom)));
            commit_line();
         end
         3: begin
            cnt = 8'($urandom_range(1, 20));
            build_record(cnt, 16'($urandom), $urandom_range(0, 1) ? 8'h00 : 8'h04);
            extra = $urandom_range(2, 2 * cnt + 1);
            while (line_buf.size() > 9 + extra) void'(line_buf.pop_back());
            commit_line();
         end
         4: begin
            cnt = 8'($urandom_range(0, 8));
            build_record(cnt, 16'($urandom), 8'h00);
            pos = $urandom_range(0, 9 + 2 * cnt);
            line_buf[1 + pos] = non_hex_char();
            commit_line();
         end
         5: begin
            build_record(8'($urandom_range(0, 8)), 16'($urandom), 8'h00);
            last = line_buf.size() - 1;
            void'(hex_digit(line_buf[last], nib));
            line_buf[last] = hex_char(nib ^ 4'($urandom_range(1, 15)));
            commit_line();
         end
         6: begin
            build_record(8'($urandom_range(0, 8)), 16'($urandom), 8'h00);
            line_buf[1 + $urandom_range(2, 5)] = non_hex_char();
            commit_line();
         end
         default: ;
      endcase
      if (pick != 0) begin
         // Once halted, nothing more may come out.
         build_record(8'd2, 16'($urandom), 8'h00);
         commit_line();
         repeat (30) send_q.push_back(8'($urandom));
         send_q.push_back(NEWLINE_CHAR);
      end

      total_chars = send_q.size();
      drain_point = total_chars / 2;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (send_q.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
